@@ rtl/humidity_pressure_temp_compensation_assert.svh @@
// Assertion macros shared by the compensation checker.
`ifndef HUMIDITY_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define HUMIDITY_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
// An implication checked one edge at a time.
`define HPTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// An implication whose consequence is checked at the next edge.
`define HPTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/hptc_pkg.sv @@
// Package with types, constants and helpers of the compensation pipeline.
package hptc_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_TEMP    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_A = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_B = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_C = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_HUM     = 3'd4;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } t_in;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic [31:0]        pressure;
        logic               pressure_div_zero;
        logic [16:0]        humidity;
    } t_out;

    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        divz;
        logic        post2;
    } t_side;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
        return 32'(a * b);
    endfunction

endpackage

@@ rtl/humidity_pressure_temp_compensation.sv @@
// Top level of the pipelined temperature, pressure and humidity compensation.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_data  (hptc_pkg::t_in)
//  output  | out       | o_valid / i_stall  | o_data  (hptc_pkg::t_out)
//  config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One sample set is taken every cycle while o_stall is low; the pipeline has ten
// arithmetic stages, the 33-stage pressure divider and three final stages.
// Reset is synchronous and clears the valid bits and the coefficients.
// When a finished result is stalled the whole pipeline holds and o_stall rises.
module humidity_pressure_temp_compensation (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  hptc_pkg::t_in             i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output hptc_pkg::t_out            o_data,
    input  logic                      i_cfg_we,
    input  logic [hptc_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [63:0]               i_cfg_data
);
    logic [47:0] r_tc, r_pa, r_pb, r_pc;
    logic [63:0] r_hc;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic        en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0; r_pa <= '0; r_pb <= '0; r_pc <= '0; r_hc <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hptc_pkg::CFG_TEMP:    r_tc <= i_cfg_data[47:0];
                hptc_pkg::CFG_PRESS_A: r_pa <= i_cfg_data[47:0];
                hptc_pkg::CFG_PRESS_B: r_pb <= i_cfg_data[47:0];
                hptc_pkg::CFG_PRESS_C: r_pc <= i_cfg_data[47:0];
                hptc_pkg::CFG_HUM:     r_hc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        t1 = 32'(r_tc[15:0]);
        t2 = 32'($signed(r_tc[31:16]));
        t3 = 32'($signed(r_tc[47:32]));
        p1 = 32'(r_pa[15:0]);
        p2 = 32'($signed(r_pa[31:16]));
        p3 = 32'($signed(r_pa[47:32]));
        p4 = 32'($signed(r_pb[15:0]));
        p5 = 32'($signed(r_pb[31:16]));
        p6 = 32'($signed(r_pb[47:32]));
        p7 = 32'($signed(r_pc[15:0]));
        p8 = 32'($signed(r_pc[31:16]));
        p9 = 32'($signed(r_pc[47:32]));
        h1 = 32'(r_hc[7:0]);
        h2 = 32'($signed(r_hc[23:8]));
        h3 = 32'(r_hc[31:24]);
        h4 = 32'($signed(r_hc[43:32]));
        h5 = 32'($signed(r_hc[55:44]));
        h6 = 32'($signed(r_hc[63:56]));
    end

    logic        r_o_vld;
    assign en      = !r_o_vld || !i_stall;
    assign o_stall = !en;

    logic [9:0]  r_vld;
    logic [31:0] r1_ma, r1_mdd, r2_v1t, r2_mb, r3_tf;
    logic [19:0] r1_ap, r2_ap, r3_ap, r4_ap, r5_ap, r6_ap;
    logic [15:0] r1_ah, r2_ah, r3_ah, r4_ah;
    logic [31:0] r4_mt, r4_q, r4_mp5, r4_mp2, r4_mh5, r4_mh6, r4_mh3;
    logic [31:0] r5_temp, r5_v2a, r5_mp3, r5_mp5, r5_mp2, r5_ha, r5_mbc;
    logic [31:0] r6_temp, r6_v2, r6_mp1, r6_me, r6_ha;
    logic [31:0] r7_temp, r7_den, r7_mpn, r7_mx;
    logic [31:0] r8_temp, r8_den, r8_num, r8_mxx, r8_x;
    logic        r8_post2, r9_post2, r10_post2;
    logic [31:0] r9_temp, r9_den, r9_num, r9_mh1, r9_x;
    logic [31:0] r10_temp, r10_den, r10_num;
    logic [16:0] r10_hum;

    logic [31:0] adct, d, pb, hb, hc, he, hf, x2, pn;

    always_comb begin
        adct = 32'(i_data.raw_temp);
        d    = (adct >> 4) - t1;
        pb   = hptc_pkg::asr(r4_mh6, 10);
        hc   = hptc_pkg::asr(r4_mh3, 11) + 32'd32768;
        he   = hptc_pkg::asr(r5_mbc, 10) + 32'd2097152;
        hf   = hptc_pkg::asr(r6_me + 32'd8192, 14);
        pn   = r7_mpn;
        x2   = r9_x - hptc_pkg::asr(r9_mh1, 4);
        hb   = x2[31] ? 32'd0 : ((x2 > hptc_pkg::HUM_MAX) ? hptc_pkg::HUM_MAX : x2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[8:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ma  <= hptc_pkg::mul((adct >> 3) - (t1 << 1), t2);
            r1_mdd <= hptc_pkg::mul(d, d);
            r1_ap  <= i_data.raw_press;
            r1_ah  <= i_data.raw_hum;

            r2_v1t <= hptc_pkg::asr(r1_ma, 11);
            r2_mb  <= hptc_pkg::mul(hptc_pkg::asr(r1_mdd, 12), t3);
            r2_ap  <= r1_ap;
            r2_ah  <= r1_ah;

            r3_tf  <= r2_v1t + hptc_pkg::asr(r2_mb, 14);
            r3_ap  <= r2_ap;
            r3_ah  <= r2_ah;

            r4_mt  <= hptc_pkg::mul(r3_tf, 32'd5);
            r4_q   <= hptc_pkg::mul(hptc_pkg::asr(hptc_pkg::asr(r3_tf, 1) - 32'd64000, 2),
                                    hptc_pkg::asr(hptc_pkg::asr(r3_tf, 1) - 32'd64000, 2));
            r4_mp5 <= hptc_pkg::mul(hptc_pkg::asr(r3_tf, 1) - 32'd64000, p5);
            r4_mp2 <= hptc_pkg::mul(p2, hptc_pkg::asr(r3_tf, 1) - 32'd64000);
            r4_mh5 <= hptc_pkg::mul(h5, r3_tf - 32'd76800);
            r4_mh6 <= hptc_pkg::mul(r3_tf - 32'd76800, h6);
            r4_mh3 <= hptc_pkg::mul(r3_tf - 32'd76800, h3);
            r4_ap  <= r3_ap;
            r4_ah  <= r3_ah;

            r5_temp <= hptc_pkg::asr(r4_mt + 32'd128, 8);
            r5_v2a  <= hptc_pkg::mul(hptc_pkg::asr(r4_q, 11), p6);
            r5_mp3  <= hptc_pkg::mul(p3, hptc_pkg::asr(r4_q, 13));
            r5_mp5  <= r4_mp5;
            r5_mp2  <= r4_mp2;
            r5_ha   <= hptc_pkg::asr((32'(r4_ah) << 14) - (h4 << 20) - r4_mh5 + 32'd16384, 15);
            r5_mbc  <= hptc_pkg::mul(pb, hc);
            r5_ap   <= r4_ap;

            r6_temp <= r5_temp;
            r6_v2   <= hptc_pkg::asr(r5_v2a + (r5_mp5 << 1), 2) + (p4 << 16);
            r6_mp1  <= hptc_pkg::mul(32'd32768 + hptc_pkg::asr(
                           hptc_pkg::asr(r5_mp3, 3) + hptc_pkg::asr(r5_mp2, 1), 18), p1);
            r6_me   <= hptc_pkg::mul(he, h2);
            r6_ha   <= r5_ha;
            r6_ap   <= r5_ap;

            r7_temp <= r6_temp;
            r7_den  <= hptc_pkg::asr(r6_mp1, 15);
            r7_mpn  <= hptc_pkg::mul((32'd1048576 - 32'(r6_ap)) - hptc_pkg::asr(r6_v2, 12),
                                     32'd3125);
            r7_mx   <= hptc_pkg::mul(r6_ha, hf);

            r8_temp  <= r7_temp;
            r8_den   <= r7_den;
            r8_post2 <= pn[31];
            r8_num   <= pn[31] ? pn : (pn << 1);
            r8_mxx   <= hptc_pkg::mul(hptc_pkg::asr(r7_mx, 15), hptc_pkg::asr(r7_mx, 15));
            r8_x     <= r7_mx;

            r9_temp  <= r8_temp;
            r9_den   <= r8_den;
            r9_num   <= r8_num;
            r9_post2 <= r8_post2;
            r9_mh1   <= hptc_pkg::mul(hptc_pkg::asr(r8_mxx, 7), h1);
            r9_x     <= r8_x;

            r10_temp  <= r9_temp;
            r10_den   <= r9_den;
            r10_num   <= r9_num;
            r10_post2 <= r9_post2;
            r10_hum   <= hb[28:12];
        end
    end

    hptc_pkg::t_side side_in, side_out;
    logic            d_vld;
    logic [31:0]     d_quot;

    always_comb begin
        side_in.temp  = r10_temp;
        side_in.hum   = r10_hum;
        side_in.divz  = (r10_den == '0);
        side_in.post2 = r10_post2;
    end

    hptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vld[9]),
        .i_num   (r10_num),
        .i_den   (r10_den),
        .i_side  (side_in),
        .o_vld   (d_vld),
        .o_quot  (d_quot),
        .o_side  (side_out)
    );

    logic            r_b1_vld, r_b2_vld;
    hptc_pkg::t_side r_b1_side, r_b2_side;
    logic [31:0]     r_b1_p, r_b1_msq, r_b1_mp8, r_b2_p, r_b2_mp9, r_b2_v2;
    logic [31:0]     pq;
    hptc_pkg::t_out  r_out;

    assign pq = side_out.post2 ? (d_quot << 1) : d_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (en) begin
            r_b1_vld <= d_vld;
            r_b2_vld <= r_b1_vld;
            r_o_vld  <= r_b2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_side <= side_out;
            r_b1_p    <= pq;
            r_b1_msq  <= hptc_pkg::mul(pq >> 3, pq >> 3);
            r_b1_mp8  <= hptc_pkg::mul(pq >> 2, p8);

            r_b2_side <= r_b1_side;
            r_b2_p    <= r_b1_p;
            r_b2_mp9  <= hptc_pkg::mul(p9, r_b1_msq >> 13);
            r_b2_v2   <= hptc_pkg::asr(r_b1_mp8, 13);

            r_out.temperature       <= r_b2_side.temp;
            r_out.pressure_div_zero <= r_b2_side.divz;
            r_out.humidity          <= r_b2_side.hum;
            r_out.pressure          <= r_b2_side.divz ? 32'd0 :
                r_b2_p + hptc_pkg::asr(hptc_pkg::asr(r_b2_mp9, 12) + r_b2_v2 + p7, 4);
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = r_out;
endmodule

@@ rtl/hptc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side data.
module hptc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [31:0]        i_num,
    input  logic [31:0]        i_den,
    input  hptc_pkg::t_side    i_side,
    output logic               o_vld,
    output logic [31:0]        o_quot,
    output hptc_pkg::t_side    o_side
);
    localparam int unsigned Steps = 32;

    logic             r_vld  [0:Steps];
    logic [31:0]      r_rem  [0:Steps];
    logic [31:0]      r_num  [0:Steps];
    logic [31:0]      r_den  [0:Steps];
    hptc_pkg::t_side  r_side [0:Steps];
    logic [31:0]      n_rem  [0:Steps-1];
    logic [31:0]      n_num  [0:Steps-1];

    always_comb begin
        logic [32:0] tmp;
        logic        ge;
        for (int k = 0; k < Steps; k++) begin
            tmp = {r_rem[k], r_num[k][31]};
            ge = tmp >= {1'b0, r_den[k]};
            n_rem[k] = ge ? 32'(tmp - {1'b0, r_den[k]}) : tmp[31:0];
            n_num[k] = {r_num[k][30:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Steps; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 0; k < Steps; k++) r_vld[k+1] <= r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_num[0]  <= i_num;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 0; k < Steps; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_num[k+1]  <= n_num[k];
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_vld  = r_vld[Steps];
    assign o_quot = r_num[Steps];
    assign o_side = r_side[Steps];
endmodule

@@ rtl/hptc_checker.sv @@
// Port checker for the compensation block, bound to the top level.
`include "humidity_pressure_temp_compensation_assert.svh"
module hptc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input hptc_pkg::t_out o_data
);
    logic divz;
    assign divz = o_data.pressure_div_zero;

    `HPTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `HPTC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `HPTC_ASSERT_NOW(a_divz_zero, i_clk, i_rst_n, o_valid && divz, o_data.pressure == 32'd0)
    `HPTC_ASSERT_NOW(a_hum_range, i_clk, i_rst_n, o_valid, o_data.humidity <= 17'd102400)
endmodule

bind humidity_pressure_temp_compensation hptc_checker u_hptc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

@@ bench/humidity_pressure_temp_compensation_test.sv @@
// Self-checking bench for the pipelined temperature, pressure and humidity compensation.
`timescale 1ns / 100ps

module humidity_pressure_temp_compensation_test;

    typedef logic [hptc_pkg::CfgIdxW-1:0] t_cfg_idx;

    localparam logic [63:0] TEMP_TYPICAL    = 64'h0000_FC18_6743_6B70;
    localparam logic [63:0] PRESS_A_TYPICAL = 64'h0000_0BD0_D643_8E7D;
    localparam logic [63:0] PRESS_B_TYPICAL = 64'h0000_FFF9_008C_0B27;
    localparam logic [63:0] PRESS_C_TYPICAL = 64'h0000_1770_C6F8_3C8C;
    localparam logic [63:0] HUM_TYPICAL     = 64'h1E03_2139_0001_6A4B;
    localparam t_cfg_idx CFG_LAST_SPARE = 3'd7;
    localparam int PIPE_DEPTH = 46;

    class compensation_scoreboard;
        logic [47:0] temp_c, press_a, press_b, press_c;
        logic [63:0] hum_c;
        hptc_pkg::t_out expected_q[$];
        int errors;

        function new();
            temp_c = '0; press_a = '0; press_b = '0; press_c = '0; hum_c = '0;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [63:0] value);
            case (idx)
                hptc_pkg::CFG_TEMP:    temp_c  = value[47:0];
                hptc_pkg::CFG_PRESS_A: press_a = value[47:0];
                hptc_pkg::CFG_PRESS_B: press_b = value[47:0];
                hptc_pkg::CFG_PRESS_C: press_c = value[47:0];
                hptc_pkg::CFG_HUM:     hum_c   = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] sra(logic [31:0] x, int n);
            return $signed(x) >>> n;
        endfunction

        function hptc_pkg::t_out compensate(hptc_pkg::t_in s);
            logic [31:0] adc_t, adc_p, adc_h;
            logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic [31:0] h1, h2, h3, h4, h5, h6;
            logic [31:0] v1, v2, d, t_fine, q, p, x, a, b, c, e, f;
            hptc_pkg::t_out r;
            adc_t = 32'(s.raw_temp);
            adc_p = 32'(s.raw_press);
            adc_h = 32'(s.raw_hum);
            t1 = 32'(temp_c[15:0]);
            t2 = 32'($signed(temp_c[31:16]));
            t3 = 32'($signed(temp_c[47:32]));
            p1 = 32'(press_a[15:0]);
            p2 = 32'($signed(press_a[31:16]));
            p3 = 32'($signed(press_a[47:32]));
            p4 = 32'($signed(press_b[15:0]));
            p5 = 32'($signed(press_b[31:16]));
            p6 = 32'($signed(press_b[47:32]));
            p7 = 32'($signed(press_c[15:0]));
            p8 = 32'($signed(press_c[31:16]));
            p9 = 32'($signed(press_c[47:32]));
            h1 = 32'(hum_c[7:0]);
            h2 = 32'($signed(hum_c[23:8]));
            h3 = 32'(hum_c[31:24]);
            h4 = 32'($signed(hum_c[43:32]));
            h5 = 32'($signed(hum_c[55:44]));
            h6 = 32'($signed(hum_c[63:56]));

            v1 = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
            d = (adc_t >> 4) - t1;
            v2 = sra(sra(d * d, 12) * t3, 14);
            t_fine = v1 + v2;
            r.temperature = sra(t_fine * 32'd5 + 32'd128, 8);

            v1 = sra(t_fine, 1) - 32'd64000;
            q = sra(v1, 2) * sra(v1, 2);
            v2 = sra(q, 11) * p6;
            v2 = v2 + ((v1 * p5) << 1);
            v2 = sra(v2, 2) + (p4 << 16);
            v1 = sra(sra(p3 * sra(q, 13), 3) + sra(p2 * v1, 1), 18);
            v1 = sra((32'd32768 + v1) * p1, 15);
            if (v1 == 32'd0) begin
                p = '0;
                r.pressure_div_zero = 1'b1;
            end else begin
                r.pressure_div_zero = 1'b0;
                p = ((32'd1048576 - adc_p) - sra(v2, 12)) * 32'd3125;
                if (p < 32'h8000_0000) begin
                    p = (p << 1) / v1;
                end else begin
                    p = (p / v1) * 32'd2;
                end
                v1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
                v2 = sra((p >> 2) * p8, 13);
                p = p + sra(v1 + v2 + p7, 4);
            end
            r.pressure = p;

            x = t_fine - 32'd76800;
            a = sra((adc_h << 14) - (h4 << 20) - (h5 * x) + 32'd16384, 15);
            b = sra(x * h6, 10);
            c = sra(x * h3, 11) + 32'd32768;
            e = sra(b * c, 10) + 32'd2097152;
            f = sra(e * h2 + 32'd8192, 14);
            x = a * f;
            x = x - sra(sra(sra(x, 15) * sra(x, 15), 7) * h1, 4);
            if (x[31]) begin
                x = '0;
            end
            if (x > 32'd419430400) begin
                x = 32'd419430400;
            end
            r.humidity = x[28:12];
            return r;
        endfunction

        function void note_sample(hptc_pkg::t_in s);
            expected_q.push_back(compensate(s));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got %h, expected %h", what, got, want);
        endtask

        task check_result(hptc_pkg::t_out got);
            hptc_pkg::t_out want;
            if (expected_q.size() == 0) begin
                report("unexpected result", got.pressure, '0);
                return;
            end
            want = expected_q.pop_front();
            if (got.temperature !== want.temperature)
                report("temperature", got.temperature, want.temperature);
            if (got.pressure !== want.pressure)
                report("pressure", got.pressure, want.pressure);
            if (got.pressure_div_zero !== want.pressure_div_zero)
                report("pressure_div_zero", 32'(got.pressure_div_zero),
                       32'(want.pressure_div_zero));
            if (got.humidity !== want.humidity)
                report("humidity", 32'(got.humidity), 32'(want.humidity));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    hptc_pkg::t_in i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    hptc_pkg::t_out o_data;
    logic i_cfg_we = 1'b0;
    t_cfg_idx i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    int send_idle = 0;
    int recv_idle = 0;
    compensation_scoreboard sb = new();

    humidity_pressure_temp_compensation i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_sample(i_data);
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        sb.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_coeffs(logic [63:0] tc, logic [63:0] pa, logic [63:0] pb,
                               logic [63:0] pc, logic [63:0] hc);
        write_reg(hptc_pkg::CFG_TEMP, tc);
        write_reg(hptc_pkg::CFG_PRESS_A, pa);
        write_reg(hptc_pkg::CFG_PRESS_B, pb);
        write_reg(hptc_pkg::CFG_PRESS_C, pc);
        write_reg(hptc_pkg::CFG_HUM, hc);
    endtask

    task automatic send_sample(hptc_pkg::t_in s);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= s;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic hptc_pkg::t_in random_sample();
        hptc_pkg::t_in s;
        s.raw_temp = 20'($urandom);
        s.raw_press = 20'($urandom);
        s.raw_hum = 16'($urandom);
        if ($urandom_range(99) < 80) begin
            s.raw_temp = 20'($urandom_range(600000, 400000));
            s.raw_press = 20'($urandom_range(500000, 250000));
            s.raw_hum = 16'($urandom_range(45000, 20000));
        end
        return s;
    endfunction

    function automatic logic [63:0] wide_rand();
        return {$urandom, $urandom};
    endfunction

    task automatic run_phase(int count);
        repeat (count) send_sample(random_sample());
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 7;
        recv_idle = 59;

        load_coeffs(TEMP_TYPICAL, PRESS_A_TYPICAL, PRESS_B_TYPICAL, PRESS_C_TYPICAL,
                    HUM_TYPICAL);
        send_sample('{20'd519888, 20'd415148, 16'd30000});
        send_sample('{20'd0, 20'd0, 16'd0});
        send_sample('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        send_sample('{20'hFFFFF, 20'd0, 16'd0});
        send_sample('{20'd0, 20'hFFFFF, 16'hFFFF});
        send_sample('{20'd519888, 20'd0, 16'hFFFF});
        send_sample('{20'd519888, 20'hFFFFF, 16'd0});
        send_sample('{20'h55555, 20'hAAAAA, 16'h5555});
        send_sample('{20'hAAAAA, 20'h55555, 16'hAAAA});
        send_sample('{20'd440000, 20'd300000, 16'd50000});
        drain();

        // A zero P1 forces the pressure divisor to zero.
        write_reg(hptc_pkg::CFG_PRESS_A, {16'hFFFF, PRESS_A_TYPICAL[47:16], 16'h0000});
        send_sample('{20'd519888, 20'd415148, 16'd30000});
        send_sample('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        drain();

        // Writes to unused indexes must leave the coefficients alone.
        for (int i = int'(hptc_pkg::CFG_HUM) + 1; i <= int'(CFG_LAST_SPARE); i++)
            write_reg(t_cfg_idx'(i), '1);
        write_reg(hptc_pkg::CFG_PRESS_A, {16'hDEAD, PRESS_A_TYPICAL[47:0]});
        run_phase(90);

        load_coeffs(wide_rand(), wide_rand(), wide_rand(), wide_rand(), wide_rand());
        run_phase(90);

        send_idle = 59;
        recv_idle = 7;
        load_coeffs('1, '1, '1, '1, '1);
        run_phase(90);
        load_coeffs(TEMP_TYPICAL ^ 64'($urandom_range(255)), PRESS_A_TYPICAL,
                    PRESS_B_TYPICAL ^ 64'($urandom_range(255)), PRESS_C_TYPICAL,
                    HUM_TYPICAL ^ 64'($urandom_range(255)));
        run_phase(90);

        send_idle = 0;
        recv_idle = 0;
        load_coeffs('0, '0, '0, '0, '0);
        run_phase(60);
        load_coeffs(64'({16'h8000, 16'h8000, 16'h8000}), 64'({16'h8000, 16'h8000, 16'hFFFF}),
                    64'({16'h7FFF, 16'h8000, 16'h7FFF}), 64'({16'h8000, 16'h7FFF, 16'h8000}),
                    64'h7F80_07FF_FF80_00FF);
        run_phase(60);
        load_coeffs(TEMP_TYPICAL, PRESS_A_TYPICAL, PRESS_B_TYPICAL, PRESS_C_TYPICAL,
                    HUM_TYPICAL);
        run_phase(90);

        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
